/* hw/rtl/owtr_pkg.sv */
// ----------------------------------------------------------------------------
// owtr_pkg: shared types and constants of the one-wire temperature reader
// payload structs, configuration layout, bus drive and status codes
// ----------------------------------------------------------------------------
package owtr_pkg;

  localparam int TimerW   = 20;
  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_RECOVER = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CONV_WAIT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_LOW     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_SLOT    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_READ_RECOVER  = 3'd7;

  // bus drive codes
  localparam logic [1:0] DRV_REL  = 2'd0;
  localparam logic [1:0] DRV_LOW  = 2'd1;
  localparam logic [1:0] DRV_HIGH = 2'd2;

  // completion status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
  localparam logic [1:0] ST_ALL_ONES    = 2'd2;

  // device commands
  localparam logic [7:0] CMD_SKIP     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;
  localparam logic [15:0] TEMP_ERROR    = 16'hFFFF;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [7:0]  presence_wait_ticks;
    logic [9:0]  reset_recover_ticks;
    logic [19:0] conversion_wait_ticks;
    logic [3:0]  write_low_ticks;
    logic [7:0]  write_slot_ticks;
    logic [5:0]  read_sample_ticks;
    logic [7:0]  read_recover_ticks;
  } owtr_cfg_t;

  localparam owtr_cfg_t CFG_RESET_VALUE = '{
    reset_low_ticks:       10'd480,
    presence_wait_ticks:   8'd70,
    reset_recover_ticks:   10'd410,
    conversion_wait_ticks: 20'd800000,
    write_low_ticks:       4'd2,
    write_slot_ticks:      8'd60,
    read_sample_ticks:     6'd15,
    read_recover_ticks:    8'd45
  };

  typedef struct packed {
    logic cmd;
    logic line_level;
  } owtr_in_t;

  typedef struct packed {
    logic [1:0]  bus_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] temperature;
  } owtr_out_t;

endpackage

/* hw/rtl/owtr_seq.sv */
// ----------------------------------------------------------------------------
// owtr_seq: bus sequencer of the one-wire temperature reader
// advances the reset / write / convert / read sequence by one tick per step
// ----------------------------------------------------------------------------
module owtr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  owtr_pkg::owtr_in_t  tick_i,
  input  owtr_pkg::owtr_cfg_t cfg_i,
  output owtr_pkg::owtr_out_t res_o
);
  import owtr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_WR_LOW, PH_WR_BODY,
    PH_CONV, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
  } phase_e;

  typedef enum logic [2:0] {
    K_RST_LOW, K_RST_WAIT, K_RST_REC, K_WRITE, K_CONV, K_READ
  } kind_e;

  // sequence segments in order
  localparam int NumSeg = 13;
  localparam logic [3:0] SEG_RST1_LOW  = 4'd0;
  localparam logic [3:0] SEG_RST1_WAIT = 4'd1;
  localparam logic [3:0] SEG_RST1_REC  = 4'd2;
  localparam logic [3:0] SEG_W1_SKIP   = 4'd3;
  localparam logic [3:0] SEG_W1_CONV   = 4'd4;
  localparam logic [3:0] SEG_CONV_WAIT = 4'd5;
  localparam logic [3:0] SEG_RST2_LOW  = 4'd6;
  localparam logic [3:0] SEG_RST2_WAIT = 4'd7;
  localparam logic [3:0] SEG_RST2_REC  = 4'd8;
  localparam logic [3:0] SEG_W2_SKIP   = 4'd9;
  localparam logic [3:0] SEG_W2_READ   = 4'd10;
  localparam logic [3:0] SEG_RD_LO     = 4'd11;
  localparam logic [3:0] SEG_RD_HI     = 4'd12;

  typedef struct packed {
    phase_e            phase;
    logic [3:0]        seg;
    logic [TimerW-1:0] timer;
    logic [2:0]        bit_idx;
    logic [7:0]        shift;
    logic [7:0]        low;
    logic              pres;
    logic              fin;
    logic [1:0]        status;
    logic [15:0]       temp;
  } seq_t;

  function automatic kind_e seg_kind(logic [3:0] sg);
    kind_e k;
    case (sg)
      SEG_RST1_LOW, SEG_RST2_LOW:                        k = K_RST_LOW;
      SEG_RST1_WAIT, SEG_RST2_WAIT:                      k = K_RST_WAIT;
      SEG_RST1_REC, SEG_RST2_REC:                        k = K_RST_REC;
      SEG_W1_SKIP, SEG_W1_CONV, SEG_W2_SKIP, SEG_W2_READ: k = K_WRITE;
      SEG_CONV_WAIT:                                     k = K_CONV;
      default:                                           k = K_READ;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] write_byte(logic [3:0] sg);
    logic [7:0] b;
    case (sg)
      SEG_W1_SKIP, SEG_W2_SKIP: b = CMD_SKIP;
      SEG_W1_CONV:              b = CMD_CONVERT;
      SEG_W2_READ:              b = CMD_READ_PAD;
      default:                  b = '0;
    endcase
    return b;
  endfunction

  function automatic seq_t finish(seq_t s, logic [1:0] st, logic [15:0] t);
    seq_t r;
    r        = s;
    r.phase  = PH_IDLE;
    r.timer  = '0;
    r.fin    = 1'b1;
    r.status = st;
    r.temp   = t;
    return r;
  endfunction

  // walk forward from segment k, passing over zero-length segments
  function automatic seq_t enter_seg(seq_t s, logic [3:0] k, logic line, owtr_cfg_t c);
    seq_t       r;
    logic       run;
    logic [3:0] j4;
    r   = s;
    run = 1'b1;
    for (int j = 0; j < NumSeg; j++) begin
      j4 = 4'(j);
      if (run && (j4 >= k)) begin
        r.seg = j4;
        case (seg_kind(j4))
          K_RST_LOW: begin
            if (c.reset_low_ticks != '0) begin
              run     = 1'b0;
              r.phase = PH_RST_LOW;
              r.timer = TimerW'(c.reset_low_ticks);
            end
          end
          K_RST_WAIT: begin
            if (c.presence_wait_ticks != '0) begin
              run     = 1'b0;
              r.phase = PH_RST_WAIT;
              r.timer = TimerW'(c.presence_wait_ticks);
            end else begin
              r.pres = ~line;
            end
          end
          K_RST_REC: begin
            if (c.reset_recover_ticks != '0) begin
              run     = 1'b0;
              r.phase = PH_RST_REC;
              r.timer = TimerW'(c.reset_recover_ticks);
            end else if (!r.pres) begin
              run = 1'b0;
              r   = finish(r, ST_NO_PRESENCE, TEMP_ERROR);
            end
          end
          K_WRITE: begin
            if ((c.write_low_ticks != '0) || (c.write_slot_ticks != '0)) begin
              run       = 1'b0;
              r.bit_idx = '0;
              if (c.write_low_ticks != '0) begin
                r.phase = PH_WR_LOW;
                r.timer = TimerW'(c.write_low_ticks);
              end else begin
                r.phase = PH_WR_BODY;
                r.timer = TimerW'(c.write_slot_ticks);
              end
            end
          end
          K_CONV: begin
            if (c.conversion_wait_ticks != '0) begin
              run     = 1'b0;
              r.phase = PH_CONV;
              r.timer = TimerW'(c.conversion_wait_ticks);
            end
          end
          default: begin
            run       = 1'b0;
            r.phase   = PH_RD_LOW;
            r.timer   = TimerW'(1);
            r.bit_idx = '0;
            r.shift   = '0;
          end
        endcase
      end
    end
    return r;
  endfunction

  // the current phase has run out this tick
  function automatic seq_t expire(seq_t s, logic line, owtr_cfg_t c);
    seq_t       r;
    logic [3:0] nxt;
    r   = s;
    nxt = s.seg + 4'd1;
    case (s.phase)
      PH_RST_LOW, PH_CONV: r = enter_seg(r, nxt, line, c);
      PH_RST_WAIT: begin
        r.pres = ~line;
        r      = enter_seg(r, nxt, line, c);
      end
      PH_RST_REC: begin
        if (!r.pres) begin
          r = finish(r, ST_NO_PRESENCE, TEMP_ERROR);
        end else begin
          r = enter_seg(r, nxt, line, c);
        end
      end
      PH_WR_LOW, PH_WR_BODY: begin
        if ((s.phase == PH_WR_LOW) && (c.write_slot_ticks != '0)) begin
          r.phase = PH_WR_BODY;
          r.timer = TimerW'(c.write_slot_ticks);
        end else if (s.bit_idx != 3'd7) begin
          r.bit_idx = s.bit_idx + 3'd1;
          if (c.write_low_ticks != '0) begin
            r.phase = PH_WR_LOW;
            r.timer = TimerW'(c.write_low_ticks);
          end else begin
            r.phase = PH_WR_BODY;
            r.timer = TimerW'(c.write_slot_ticks);
          end
        end else begin
          r = enter_seg(r, nxt, line, c);
        end
      end
      PH_RD_LOW, PH_RD_WAIT, PH_RD_REC: begin
        if ((s.phase == PH_RD_LOW) && (c.read_sample_ticks != '0)) begin
          r.phase = PH_RD_WAIT;
          r.timer = TimerW'(c.read_sample_ticks);
        end else if ((s.phase != PH_RD_REC) && (c.read_recover_ticks != '0)) begin
          r.shift[s.bit_idx] = line;
          r.phase            = PH_RD_REC;
          r.timer            = TimerW'(c.read_recover_ticks);
        end else begin
          if (s.phase != PH_RD_REC) begin
            r.shift[s.bit_idx] = line;
          end
          if (s.bit_idx != 3'd7) begin
            r.bit_idx = s.bit_idx + 3'd1;
            r.phase   = PH_RD_LOW;
            r.timer   = TimerW'(1);
          end else if (s.seg == SEG_RD_LO) begin
            r.low = r.shift;
            r     = enter_seg(r, nxt, line, c);
          end else if ((r.low == BYTE_ALL_ONES) && (r.shift == BYTE_ALL_ONES)) begin
            r = finish(r, ST_ALL_ONES, TEMP_ERROR);
          end else begin
            r = finish(r, ST_OK, {r.shift, r.low});
          end
        end
      end
      default: r = finish(r, ST_OK, '0);
    endcase
    return r;
  endfunction

  function automatic logic [1:0] drive_of(seq_t s);
    logic [1:0] d;
    logic [7:0] b;
    b = write_byte(s.seg);
    case (s.phase)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: d = DRV_LOW;
      PH_WR_BODY:                       d = b[s.bit_idx] ? DRV_HIGH : DRV_LOW;
      PH_CONV:                          d = DRV_HIGH;
      default:                          d = DRV_REL;
    endcase
    return d;
  endfunction

  phase_e            phase_q;
  logic [3:0]        seg_q;
  logic [TimerW-1:0] timer_q;
  logic [2:0]        bit_q;
  logic [7:0]        shift_q;
  logic [7:0]        low_q;
  logic              pres_q;

  seq_t cur, sa, sb;
  logic start;

  always_comb begin
    cur.phase   = phase_q;
    cur.seg     = seg_q;
    cur.timer   = timer_q;
    cur.bit_idx = bit_q;
    cur.shift   = shift_q;
    cur.low     = low_q;
    cur.pres    = pres_q;
    cur.fin     = 1'b0;
    cur.status  = ST_OK;
    cur.temp    = '0;

    // start of a new read sequence
    start = (phase_q == PH_IDLE) && tick_i.cmd;
    sa    = cur;
    if (start) begin
      sa.bit_idx = '0;
      sa.shift   = '0;
      sa.low     = '0;
      sa.pres    = 1'b0;
      sa         = enter_seg(sa, SEG_RST1_LOW, tick_i.line_level, cfg_i);
    end

    // count down, move on when the phase runs out
    sb = sa;
    if (sa.phase != PH_IDLE) begin
      sb.timer = sa.timer - TimerW'(1);
      if (sa.timer == TimerW'(1)) begin
        sb = expire(sa, tick_i.line_level, cfg_i);
      end
    end

    res_o.bus_drive   = drive_of(sa);
    res_o.busy_res    = (phase_q != PH_IDLE) || tick_i.cmd;
    res_o.done_res    = sb.fin;
    res_o.status      = sb.fin ? sb.status : ST_OK;
    res_o.temperature = sb.fin ? sb.temp : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seg_q   <= '0;
      timer_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      low_q   <= '0;
      pres_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= sb.phase;
      seg_q   <= sb.seg;
      timer_q <= sb.timer;
      bit_q   <= sb.bit_idx;
      shift_q <= sb.shift;
      low_q   <= sb.low;
      pres_q  <= sb.pres;
    end
  end

endmodule

/* hw/rtl/one_wire_temperature_reader.sv */
// ----------------------------------------------------------------------------
// one_wire_temperature_reader: one-wire bus master reading a temperature
// one request is one bus tick; a start request runs reset, convert and read
// ----------------------------------------------------------------------------
// path: request held in the input register, then result in the result register;
//   throughput: one request per cycle while the receiver does not stall, set by
//   the combinational sequencer update between the two registers
// reset: asynchronous, sequencer idle with line released, registers at their
//   default timing values; no clearing pass, requests taken right after reset
module one_wire_temperature_reader (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tick requests
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  owtr_pkg::owtr_in_t                   in_data_i,
  // per-tick results
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output owtr_pkg::owtr_out_t                  out_data_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [owtr_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [owtr_pkg::CfgDataW-1:0]        cfg_wdata_i
);
  import owtr_pkg::*;

  owtr_cfg_t cfg_q;

  // input register
  logic     in_valid_q;
  owtr_in_t in_data_q;

  // result register
  logic      out_valid_q;
  owtr_out_t out_data_q;

  owtr_out_t seq_res;
  logic      advance;

  // the held request moves into the result register when that is free or
  // being drained this cycle; the sequencer state steps at the same edge
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // timing registers: user writes only while no request is in flight (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET_VALUE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESET_LOW:     cfg_q.reset_low_ticks       <= cfg_wdata_i[9:0];
        CFG_PRESENCE_WAIT: cfg_q.presence_wait_ticks   <= cfg_wdata_i[7:0];
        CFG_RESET_RECOVER: cfg_q.reset_recover_ticks   <= cfg_wdata_i[9:0];
        CFG_CONV_WAIT:     cfg_q.conversion_wait_ticks <= cfg_wdata_i[19:0];
        CFG_WRITE_LOW:     cfg_q.write_low_ticks       <= cfg_wdata_i[3:0];
        CFG_WRITE_SLOT:    cfg_q.write_slot_ticks      <= cfg_wdata_i[7:0];
        CFG_READ_SAMPLE:   cfg_q.read_sample_ticks     <= cfg_wdata_i[5:0];
        CFG_READ_RECOVER:  cfg_q.read_recover_ticks    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // input stage: take a new request when none is held or the held one leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // sequencer: one bus tick per advancing request
  owtr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (in_data_q),
    .cfg_i  (cfg_q),
    .res_o  (seq_res)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= seq_res;
    end
  end

endmodule

/* tb/one_wire_temperature_reader_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_tb: self-checking bench for the 1-wire reader
// every tick request is predicted by an in-bench sequencer model and each
// per-tick result is compared field by field; a small device model answers
// presence and read slots so that whole read sequences run to completion
// ----------------------------------------------------------------------------
module one_wire_temperature_reader_tb;
  import owtr_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int RandomTicks = 900;
  localparam int RandomReads = 6;
  localparam int RunLimitNs  = 12_000_000;

  // sequencer phases of the bench model
  typedef enum logic [3:0] {
    S_IDLE, S_RST_LOW, S_PRESENCE, S_RST_REC, S_WR_OPEN, S_WR_BIT, S_CONVERT,
    S_RD_OPEN, S_RD_SAMPLE, S_RD_REC
  } reader_phase_e;

  // position within the fixed command sequence
  typedef enum logic [2:0] {
    STG_FIRST_RESET, STG_SKIP_FIRST, STG_CONVERT, STG_SECOND_RESET,
    STG_SKIP_SECOND, STG_READ_PAD, STG_LOW_BYTE, STG_HIGH_BYTE
  } reader_stage_e;

  // named timing sets used by the directed part
  typedef enum logic [1:0] {PROF_RESET, PROF_FAST, PROF_LONG_CONV} timing_prof_e;

  typedef struct packed {
    logic        start;
    logic        line;
    logic [1:0]  prof;
    logic        present;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        cmd_busy;
    logic        pinned;
    logic [1:0]  status;
    logic [15:0] temp;
  } plan_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  owtr_in_t            in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_ready_o;
  logic                out_valid_o;
  owtr_out_t           out_data_o;

  // bench model state
  owtr_cfg_t     timing     = CFG_RESET_VALUE;
  reader_phase_e rd_phase   = S_IDLE;
  reader_stage_e stage      = STG_FIRST_RESET;
  logic [19:0]   tmr        = '0;
  logic [7:0]    shift_reg  = '0;
  logic [2:0]    bit_idx    = '0;
  logic [7:0]    low_held   = '0;
  logic [15:0]   held_temp  = '0;
  logic          presence_seen = 1'b0;
  logic          done_now   = 1'b0;
  logic [1:0]    done_status = ST_OK;

  // device answers for the read in flight
  logic       dev_present = 1'b1;
  logic [7:0] dev_lo = '0;
  logic [7:0] dev_hi = '0;

  // typed expectations from the directed table
  logic        pin_idle   = 1'b0;
  logic        pin_done   = 1'b0;
  logic [1:0]  pin_status = ST_OK;
  logic [15:0] pin_temp   = '0;

  owtr_out_t expected_ticks[$];
  plan_row_t plan[$];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        ticks_sent   = 0;
  int        send_idle_pct = 28;
  int        recv_idle_pct = 85;

  one_wire_temperature_reader u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("one_wire_temperature_reader_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic void conclude(input logic [1:0] st, input logic [15:0] t);
    rd_phase    = S_IDLE;
    tmr         = '0;
    done_now    = 1'b1;
    done_status = st;
    held_temp   = t;
  endfunction

  function automatic void begin_write_byte(input logic [7:0] b);
    shift_reg = b;
    bit_idx   = '0;
    rd_phase  = S_WR_OPEN;
    tmr       = 20'(timing.write_low_ticks);
  endfunction

  function automatic void begin_read_byte();
    shift_reg = '0;
    bit_idx   = '0;
    rd_phase  = S_RD_OPEN;
    tmr       = 20'd1;
  endfunction

  // close every phase whose time has run out; zero-length phases fall through
  function automatic void settle(input logic line);
    while (rd_phase != S_IDLE && tmr == '0) begin
      case (rd_phase)
        S_RST_LOW: begin
          rd_phase = S_PRESENCE;
          tmr      = 20'(timing.presence_wait_ticks);
        end
        S_PRESENCE: begin
          presence_seen = (line == 1'b0);
          rd_phase      = S_RST_REC;
          tmr           = 20'(timing.reset_recover_ticks);
        end
        S_RST_REC: begin
          if (!presence_seen) begin
            conclude(ST_NO_PRESENCE, TEMP_ERROR);
          end else begin
            stage = (stage == STG_FIRST_RESET) ? STG_SKIP_FIRST : STG_SKIP_SECOND;
            begin_write_byte(CMD_SKIP);
          end
        end
        S_WR_OPEN: begin
          rd_phase = S_WR_BIT;
          tmr      = 20'(timing.write_slot_ticks);
        end
        S_WR_BIT: begin
          shift_reg = shift_reg >> 1;
          if (bit_idx < 3'd7) begin
            bit_idx  = bit_idx + 3'd1;
            rd_phase = S_WR_OPEN;
            tmr      = 20'(timing.write_low_ticks);
          end else if (stage == STG_SKIP_FIRST) begin
            stage = STG_CONVERT;
            begin_write_byte(CMD_CONVERT);
          end else if (stage == STG_CONVERT) begin
            rd_phase = S_CONVERT;
            tmr      = timing.conversion_wait_ticks;
          end else if (stage == STG_SKIP_SECOND) begin
            stage = STG_READ_PAD;
            begin_write_byte(CMD_READ_PAD);
          end else begin
            stage = STG_LOW_BYTE;
            begin_read_byte();
          end
        end
        S_CONVERT: begin
          stage    = STG_SECOND_RESET;
          rd_phase = S_RST_LOW;
          tmr      = 20'(timing.reset_low_ticks);
        end
        S_RD_OPEN: begin
          rd_phase = S_RD_SAMPLE;
          tmr      = 20'(timing.read_sample_ticks);
        end
        S_RD_SAMPLE: begin
          shift_reg[bit_idx] = shift_reg[bit_idx] | line;
          rd_phase = S_RD_REC;
          tmr      = 20'(timing.read_recover_ticks);
        end
        S_RD_REC: begin
          if (bit_idx < 3'd7) begin
            bit_idx  = bit_idx + 3'd1;
            rd_phase = S_RD_OPEN;
            tmr      = 20'd1;
          end else if (stage == STG_LOW_BYTE) begin
            low_held = shift_reg;
            stage    = STG_HIGH_BYTE;
            begin_read_byte();
          end else if (low_held == BYTE_ALL_ONES && shift_reg == BYTE_ALL_ONES) begin
            conclude(ST_ALL_ONES, TEMP_ERROR);
          end else begin
            conclude(ST_OK, {shift_reg, low_held});
          end
        end
        default: conclude(ST_OK, '0);
      endcase
    end
  endfunction

  // one bus tick: start check, phase ends, line drive, timer step
  function automatic owtr_out_t predict_tick(input owtr_in_t req);
    owtr_out_t  res;
    logic       busy;
    logic [1:0] drv;
    done_now    = 1'b0;
    done_status = ST_OK;
    if (rd_phase == S_IDLE && req.cmd) begin
      stage         = STG_FIRST_RESET;
      bit_idx       = '0;
      shift_reg     = '0;
      low_held      = '0;
      presence_seen = 1'b0;
      rd_phase      = S_RST_LOW;
      tmr           = 20'(timing.reset_low_ticks);
    end
    busy = (rd_phase != S_IDLE);
    if (busy) settle(req.line_level);
    case (rd_phase)
      S_RST_LOW, S_WR_OPEN, S_RD_OPEN: drv = DRV_LOW;
      S_WR_BIT:  drv = shift_reg[0] ? DRV_HIGH : DRV_LOW;
      S_CONVERT: drv = DRV_HIGH;
      default:   drv = DRV_REL;
    endcase
    if (rd_phase != S_IDLE) begin
      tmr = tmr - 20'd1;
      settle(req.line_level);
    end
    res.bus_drive   = drv;
    res.busy_res    = busy;
    res.done_res    = done_now;
    res.status      = done_now ? done_status : ST_OK;
    res.temperature = done_now ? held_temp : '0;
    return res;
  endfunction

  // bus level the device shows this tick: pulls low for presence, then read bits
  function automatic logic device_line();
    logic [7:0] b;
    case (rd_phase)
      S_PRESENCE:  return !dev_present;
      S_RD_SAMPLE: begin
        b = (stage == STG_LOW_BYTE) ? dev_lo : dev_hi;
        return b[bit_idx];
      end
      default:     return 1'($urandom_range(1));
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_tick(input logic cmd, input logic line);
    owtr_in_t  req;
    owtr_out_t want;
    req.cmd        = cmd;
    req.line_level = line;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = predict_tick(req);
    if (pin_idle) begin
      want.bus_drive   = DRV_REL;
      want.busy_res    = 1'b0;
      want.done_res    = 1'b0;
      want.status      = ST_OK;
      want.temperature = '0;
      pin_idle = 1'b0;
    end
    if (pin_done && want.done_res) begin
      want.status      = pin_status;
      want.temperature = pin_temp;
      pin_done = 1'b0;
    end
    expected_ticks.push_back(want);
    ticks_sent++;
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_RESET_LOW:     timing.reset_low_ticks       = val[9:0];
      CFG_PRESENCE_WAIT: timing.presence_wait_ticks   = val[7:0];
      CFG_RESET_RECOVER: timing.reset_recover_ticks   = val[9:0];
      CFG_CONV_WAIT:     timing.conversion_wait_ticks = val[19:0];
      CFG_WRITE_LOW:     timing.write_low_ticks       = val[3:0];
      CFG_WRITE_SLOT:    timing.write_slot_ticks      = val[7:0];
      CFG_READ_SAMPLE:   timing.read_sample_ticks     = val[5:0];
      CFG_READ_RECOVER:  timing.read_recover_ticks    = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_timing(input owtr_cfg_t t);
    write_reg(CFG_RESET_LOW,     CfgDataW'(t.reset_low_ticks));
    write_reg(CFG_PRESENCE_WAIT, CfgDataW'(t.presence_wait_ticks));
    write_reg(CFG_RESET_RECOVER, CfgDataW'(t.reset_recover_ticks));
    write_reg(CFG_CONV_WAIT,     CfgDataW'(t.conversion_wait_ticks));
    write_reg(CFG_WRITE_LOW,     CfgDataW'(t.write_low_ticks));
    write_reg(CFG_WRITE_SLOT,    CfgDataW'(t.write_slot_ticks));
    write_reg(CFG_READ_SAMPLE,   CfgDataW'(t.read_sample_ticks));
    write_reg(CFG_READ_RECOVER,  CfgDataW'(t.read_recover_ticks));
    cfg_we_i <= 1'b0;
  endtask

  function automatic owtr_cfg_t profile_timing(input timing_prof_e prof);
    owtr_cfg_t t;
    t = CFG_RESET_VALUE;
    // shortest legal timing, recoveries at zero
    if (prof == PROF_FAST || prof == PROF_LONG_CONV) begin
      t.reset_low_ticks       = 10'd1;
      t.presence_wait_ticks   = 8'd1;
      t.reset_recover_ticks   = '0;
      t.conversion_wait_ticks = 20'd1;
      t.write_low_ticks       = 4'd1;
      t.write_slot_ticks      = 8'd1;
      t.read_sample_ticks     = 6'd1;
      t.read_recover_ticks    = '0;
    end
    if (prof == PROF_LONG_CONV) t.conversion_wait_ticks = '1;
    return t;
  endfunction

  function automatic owtr_cfg_t rand_timing();
    owtr_cfg_t t;
    t.reset_low_ticks       = 10'($urandom_range(4, 1));
    t.presence_wait_ticks   = 8'($urandom_range(3, 1));
    t.reset_recover_ticks   = 10'($urandom_range(3));
    t.conversion_wait_ticks = 20'($urandom_range(6, 1));
    t.write_low_ticks       = 4'($urandom_range(2, 1));
    t.write_slot_ticks      = 8'($urandom_range(3, 1));
    t.read_sample_ticks     = 6'($urandom_range(3, 1));
    t.read_recover_ticks    = 8'($urandom_range(2));
    return t;
  endfunction

  // start request, then ticks with cmd at the given busy rate until the sequence reports done
  task automatic run_read(input logic present, input logic [7:0] lo, input logic [7:0] hi,
                          input int cmd_busy_pct, input logic pinned,
                          input logic [1:0] st, input logic [15:0] temp);
    dev_present = present;
    dev_lo      = lo;
    dev_hi      = hi;
    pin_done    = pinned;
    pin_status  = st;
    pin_temp    = temp;
    send_tick(1'b1, device_line());
    while (rd_phase != S_IDLE) send_tick($urandom_range(99) < cmd_busy_pct, device_line());
  endtask

  task automatic plan_row(input logic start, input logic line, input timing_prof_e prof,
                          input logic present, input logic [7:0] lo, input logic [7:0] hi,
                          input logic cmd_busy, input logic pinned,
                          input logic [1:0] st, input logic [15:0] temp);
    plan_row_t r;
    r.start    = start;
    r.line     = line;
    r.prof     = prof;
    r.present  = present;
    r.lo       = lo;
    r.hi       = hi;
    r.cmd_busy = cmd_busy;
    r.pinned   = pinned;
    r.status   = st;
    r.temp     = temp;
    plan.push_back(r);
  endtask

  // receiver side stalls at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : result_check
    owtr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %h", results_seen, out_data_o);
      end else begin
        want = expected_ticks.pop_front();
        if (out_data_o.bus_drive !== want.bus_drive || out_data_o.busy_res !== want.busy_res ||
            out_data_o.done_res !== want.done_res || out_data_o.status !== want.status ||
            out_data_o.temperature !== want.temperature) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("result %0d (expected/actual): drive %0d/%0d busy %b/%b ", results_seen,
                   want.bus_drive, out_data_o.bus_drive, want.busy_res, out_data_o.busy_res);
            $display("done %b/%b status %0d/%0d temp %h/%h",
                     want.done_res, out_data_o.done_res, want.status, out_data_o.status,
                     want.temperature, out_data_o.temperature);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    timing_prof_e cur_prof;
    int           rand_base;
    int           reads_done;
    logic         present;
    logic [7:0]   lo;
    logic [7:0]   hi;
    int           pick;

    cur_prof   = PROF_RESET;
    reads_done = 0;

    // directed table: idle ticks, all status codes, byte extremes, timing extremes
    plan_row(1'b0, 1'b0, PROF_RESET, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, ST_OK, 16'h0000);
    plan_row(1'b0, 1'b1, PROF_RESET, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, ST_OK, 16'h0000);
    plan_row(1'b1, 1'b0, PROF_FAST,  1'b1, 8'h50, 8'h05, 1'b0, 1'b1, ST_OK, 16'h0550);
    plan_row(1'b1, 1'b0, PROF_FAST,  1'b0, 8'h50, 8'h05, 1'b0, 1'b1, ST_NO_PRESENCE, TEMP_ERROR);
    plan_row(1'b1, 1'b0, PROF_FAST,  1'b1, 8'hFF, 8'hFF, 1'b0, 1'b1, ST_ALL_ONES, TEMP_ERROR);
    plan_row(1'b1, 1'b0, PROF_FAST,  1'b1, 8'hFF, 8'h00, 1'b0, 1'b1, ST_OK, 16'h00FF);
    // start requests on every busy tick must be ignored
    plan_row(1'b1, 1'b0, PROF_FAST,  1'b1, 8'hA5, 8'h5A, 1'b1, 1'b1, ST_OK, 16'h5AA5);
    plan_row(1'b1, 1'b0, PROF_FAST,  1'b1, 8'h3C, 8'hC3, 1'b0, 1'b0, ST_OK, 16'h0000);
    plan_row(1'b1, 1'b0, PROF_LONG_CONV, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, ST_NO_PRESENCE,
             TEMP_ERROR);
    plan_row(1'b0, 1'b0, PROF_LONG_CONV, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, ST_OK, 16'h0000);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].prof != cur_prof) begin
        drain();
        cur_prof = timing_prof_e'(plan[i].prof);
        load_timing(profile_timing(cur_prof));
      end
      if (plan[i].start) begin
        run_read(plan[i].present, plan[i].lo, plan[i].hi, plan[i].cmd_busy ? 100 : 0,
                 plan[i].pinned, plan[i].status, plan[i].temp);
      end else begin
        pin_idle = plan[i].pinned;
        send_tick(1'b0, plan[i].line);
      end
    end

    // random reads: mostly well-formed with random bytes, some missing devices
    rand_base = ticks_sent;
    while (ticks_sent - rand_base < RandomTicks || reads_done < RandomReads) begin
      if (reads_done == RandomReads / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 28;
      end else if (reads_done == 2 * RandomReads / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (reads_done % 2 == 0) begin
        drain();
        load_timing(rand_timing());
      end
      repeat ($urandom_range(3)) send_tick(1'b0, device_line());
      present = ($urandom_range(99) >= 15);
      lo      = 8'($urandom);
      hi      = 8'($urandom);
      pick    = $urandom_range(9);
      if (pick == 0) begin
        lo = BYTE_ALL_ONES;
        hi = BYTE_ALL_ONES;
      end else if (pick == 1) begin
        lo = BYTE_ALL_ONES;
      end else if (pick == 2) begin
        hi = BYTE_ALL_ONES;
      end
      run_read(present, lo, hi, 30, 1'b0, ST_OK, 16'h0000);
      reads_done++;
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("one_wire_temperature_reader_tb OK");
    end else begin
      $display("one_wire_temperature_reader_tb NOT OK");
    end
    $finish;
  end

endmodule
